// ===== src/stq_pkg.sv =====
`default_nettype none

package stq_pkg;

    localparam int TIME_W     = 48;
    localparam int PID_W      = 6;
    localparam int PID_COUNT  = 64;
    localparam int REQ_W      = 3;
    localparam int NUDGE_W    = 16;
    localparam int ERR_W      = 2;
    localparam int PST_W      = 2;
    localparam int FIFO_DEPTH = 2;

    localparam logic [NUDGE_W-1:0] NUDGE_RESET = 16'd100;
    localparam logic [TIME_W-1:0]  TIME_MAX    = {TIME_W{1'b1}};

    // request codes on the input channel
    localparam logic [REQ_W-1:0] REQ_APPEND = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_TIMED  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd3;
    localparam logic [REQ_W-1:0] REQ_POP    = 3'd4;
    localparam logic [REQ_W-1:0] REQ_PEEK   = 3'd5;

    localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_FULL  = 2'd1;
    localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd2;

    localparam logic [PST_W-1:0] PST_NONE    = 2'd0;
    localparam logic [PST_W-1:0] PST_WAITING = 2'd1;
    localparam logic [PST_W-1:0] PST_EXPIRED = 2'd2;

    typedef enum logic [2:0] {
        OP_APPEND,
        OP_PUSH,
        OP_TIMED,
        OP_REMOVE,
        OP_POP,
        OP_PEEK
    } t_op;

    typedef enum logic {
        ST_CMP,
        ST_APPLY
    } t_back_state;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [PID_W-1:0]  pid;
        logic [TIME_W-1:0] wake_time;
        logic [TIME_W-1:0] now;
    } t_req;

    typedef struct packed {
        logic [PID_W-1:0]  out_pid;
        logic [TIME_W-1:0] out_time;
        logic              queue_empty;
        logic              found;
        logic [ERR_W-1:0]  error;
        logic [PST_W-1:0]  pid_state;
    } t_rsp;

    // classified request handed from front to back
    typedef struct packed {
        t_op               op;
        logic [PID_W-1:0]  pid;
        logic [TIME_W-1:0] wake;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_back_stat;

endpackage

`default_nettype wire

// ===== src/stq_if.sv =====
`default_nettype none

interface stq_if #(
    parameter type t_data = logic
);
    logic  valid;
    logic  ready;
    t_data data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/stq_front.sv =====
`default_nettype none

module stq_front
    import stq_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_we,
    input  wire [NUDGE_W-1:0]   i_cfg_wdata,
    stq_if.sink                 i_req,
    stq_if.source               o_cmd
);

    logic [NUDGE_W-1:0] r_nudge;
    logic [TIME_W:0]    nudged_sum;
    logic [TIME_W-1:0]  timed_wake;
    t_req               req;
    t_cmd               cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nudge <= NUDGE_RESET;
        end else if (i_cfg_we) begin
            r_nudge <= i_cfg_wdata;
        end
    end

    assign req = i_req.data;

    // timed insert equal to now moves later, saturating at the top
    assign nudged_sum = {1'b0, req.wake_time} + {{(TIME_W + 1 - NUDGE_W){1'b0}}, r_nudge};

    always_comb begin
        if (req.wake_time != req.now) begin
            timed_wake = req.wake_time;
        end else if (nudged_sum[TIME_W]) begin
            timed_wake = TIME_MAX;
        end else begin
            timed_wake = nudged_sum[TIME_W-1:0];
        end
    end

    always_comb begin
        cmd.pid  = req.pid;
        cmd.wake = req.wake_time;
        case (req.req_type)
            REQ_APPEND: begin
                cmd.op = OP_APPEND;
            end
            REQ_PUSH: begin
                cmd.op   = OP_PUSH;
                cmd.wake = req.now;
            end
            REQ_TIMED: begin
                cmd.op   = OP_TIMED;
                cmd.wake = timed_wake;
            end
            REQ_REMOVE: begin
                cmd.op = OP_REMOVE;
            end
            REQ_POP: begin
                cmd.op = OP_POP;
            end
            default: begin
                cmd.op = OP_PEEK;   // peek and unused codes
            end
        endcase
    end

    assign o_cmd.valid = i_req.valid;
    assign o_cmd.data  = cmd;
    assign i_req.ready = o_cmd.ready;

endmodule

`default_nettype wire

// ===== src/stq_fifo.sv =====
`default_nettype none

module stq_fifo
    import stq_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    stq_if.sink   i_cmd,
    stq_if.source o_cmd
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    t_cmd             r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             wr_en;
    logic             rd_en;

    assign i_cmd.ready = (r_count != CNT_W'(FIFO_DEPTH));
    assign o_cmd.valid = (r_count != '0);
    assign o_cmd.data  = r_mem[r_rd_ptr];

    assign wr_en = i_cmd.valid && i_cmd.ready;
    assign rd_en = o_cmd.valid && o_cmd.ready;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_cmd.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/stq_back.sv =====
`default_nettype none

module stq_back
    import stq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    stq_if.sink         i_cmd,
    stq_if.source       o_rsp,
    output t_back_stat  o_stat
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // sorted queue: entry 0 is the head
    logic [PID_W-1:0]       r_pid  [QUEUE_DEPTH];
    logic [TIME_W-1:0]      r_time [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] r_cur;
    logic [CNT_W-1:0]       r_count;

    logic [PID_W-1:0]       n_pid  [QUEUE_DEPTH];
    logic [TIME_W-1:0]      n_time [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] n_cur;
    logic [CNT_W-1:0]       n_count;

    // compare stage results
    t_back_state            r_state;
    t_cmd                   r_cmd;
    logic [PID_W-1:0]       r_key;
    logic [QUEUE_DEPTH-1:0] r_eq;
    logic [QUEUE_DEPTH-1:0] r_lt;

    // per-pid timeout state, valid bit per entry
    logic [PST_W-1:0]       ts_mem [PID_COUNT];
    logic [PID_COUNT-1:0]   r_ts_vld;
    logic [PST_W-1:0]       r_ts_rd;
    logic                   r_ts_hit;

    t_rsp                   r_out;
    logic                   r_out_vld;

    logic [PID_W-1:0]       key_pid;
    logic [QUEUE_DEPTH-1:0] cmp_eq;
    logic [QUEUE_DEPTH-1:0] cmp_lt;
    logic                   cmp_go;
    logic                   apply_go;
    logic                   full;
    logic                   empty;
    logic [PST_W-1:0]       ts_cur;
    logic                   ts_we;
    logic [PST_W-1:0]       ts_wdata;
    logic [QUEUE_DEPTH-1:0] ins_mask;
    logic [QUEUE_DEPTH-1:0] rm_match;
    logic [QUEUE_DEPTH-1:0] rm_mask;
    logic [QUEUE_DEPTH-1:0] cur_kept;
    t_rsp                   rsp;

    assign full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign empty = (r_count == '0);

    assign o_stat.full  = full;
    assign o_stat.empty = empty;

    assign i_cmd.ready = (r_state == ST_CMP);
    assign cmp_go      = i_cmd.valid && (r_state == ST_CMP);
    assign apply_go    = (r_state == ST_APPLY) && (!r_out_vld || o_rsp.ready);

    // ---------------- compare stage ----------------
    assign key_pid = (i_cmd.data.op == OP_POP || i_cmd.data.op == OP_PEEK) ?
                     r_pid[0] : i_cmd.data.pid;

    always_comb begin
        for (int j = 0; j < QUEUE_DEPTH; j++) begin
            cmp_eq[j] = (r_pid[j] == key_pid) && (CNT_W'(j) < r_count);
            cmp_lt[j] = (i_cmd.data.wake < r_time[j]) && (CNT_W'(j) < r_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmp_go) begin
            r_cmd    <= i_cmd.data;
            r_key    <= key_pid;
            r_eq     <= cmp_eq;
            r_lt     <= cmp_lt;
            r_ts_rd  <= ts_mem[key_pid];
            r_ts_hit <= r_ts_vld[key_pid];
        end
    end

    always_ff @(posedge i_clk) begin
        if (apply_go && ts_we) begin
            ts_mem[r_key] <= ts_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ts_vld <= '0;
        end else if (apply_go && ts_we) begin
            r_ts_vld[r_key] <= 1'b1;
        end
    end

    // ---------------- apply stage ----------------
    assign ts_cur   = r_ts_hit ? r_ts_rd : PST_NONE;
    assign cur_kept = r_cur & ~r_eq;
    assign rm_match = r_eq & r_cur;

    always_comb begin
        // insert point is the first slot that qualifies; every slot after it moves down
        ins_mask[0] = (r_cmd.op == OP_PUSH) || (r_count == '0) ||
                      ((r_cmd.op == OP_TIMED) && r_lt[0]);
        for (int j = 1; j < QUEUE_DEPTH; j++) begin
            ins_mask[j] = ins_mask[j-1] || (r_cmd.op == OP_PUSH) ||
                          (CNT_W'(j) >= r_count) ||
                          ((r_cmd.op == OP_TIMED) && r_lt[j]);
        end
        // entries at and after the removed one move up
        rm_mask[0] = rm_match[0];
        for (int j = 1; j < QUEUE_DEPTH; j++) begin
            rm_mask[j] = rm_mask[j-1] | rm_match[j];
        end
    end

    always_comb begin
        n_pid    = r_pid;
        n_time   = r_time;
        n_cur    = r_cur;
        n_count  = r_count;
        ts_we    = 1'b0;
        ts_wdata = PST_NONE;
        rsp      = '0;
        case (r_cmd.op)
            OP_APPEND, OP_PUSH, OP_TIMED: begin
                if (full) begin
                    rsp.error     = ERR_FULL;
                    rsp.pid_state = ts_cur;
                end else begin
                    if (ins_mask[0]) begin
                        n_pid[0]  = r_cmd.pid;
                        n_time[0] = r_cmd.wake;
                        n_cur[0]  = 1'b1;
                    end else begin
                        n_cur[0]  = cur_kept[0];
                    end
                    for (int j = 1; j < QUEUE_DEPTH; j++) begin
                        if (ins_mask[j] && ins_mask[j-1]) begin
                            n_pid[j]  = r_pid[j-1];
                            n_time[j] = r_time[j-1];
                            n_cur[j]  = cur_kept[j-1];
                        end else if (ins_mask[j]) begin
                            n_pid[j]  = r_cmd.pid;
                            n_time[j] = r_cmd.wake;
                            n_cur[j]  = 1'b1;
                        end else begin
                            n_cur[j]  = cur_kept[j];
                        end
                    end
                    n_count = r_count + 1'b1;
                    if (r_cmd.op == OP_TIMED) begin
                        ts_we         = 1'b1;
                        ts_wdata      = PST_WAITING;
                        rsp.pid_state = PST_WAITING;
                    end else begin
                        rsp.pid_state = ts_cur;
                    end
                end
            end
            OP_REMOVE: begin
                for (int j = 0; j < QUEUE_DEPTH - 1; j++) begin
                    if (rm_mask[j]) begin
                        n_pid[j]  = r_pid[j+1];
                        n_time[j] = r_time[j+1];
                        n_cur[j]  = r_cur[j+1];
                    end
                end
                rsp.found = |rm_match;
                if (|rm_match) begin
                    n_count = r_count - 1'b1;
                end
                ts_we         = 1'b1;
                ts_wdata      = PST_NONE;
                rsp.pid_state = PST_NONE;
            end
            OP_POP: begin
                if (empty) begin
                    rsp.error = ERR_EMPTY;
                end else begin
                    rsp.out_pid  = r_pid[0];
                    rsp.out_time = r_time[0];
                    for (int j = 0; j < QUEUE_DEPTH - 1; j++) begin
                        n_pid[j]  = r_pid[j+1];
                        n_time[j] = r_time[j+1];
                        n_cur[j]  = cur_kept[j+1];
                    end
                    n_count = r_count - 1'b1;
                    ts_we   = 1'b1;
                    ts_wdata = (ts_cur == PST_WAITING) ? PST_EXPIRED : ts_cur;
                    rsp.pid_state = (ts_cur == PST_WAITING) ? PST_EXPIRED : ts_cur;
                end
            end
            default: begin
                if (!empty) begin
                    rsp.out_pid   = r_pid[0];
                    rsp.out_time  = r_time[0];
                    rsp.pid_state = ts_cur;
                end
            end
        endcase
        rsp.queue_empty = (n_count == '0);
    end

    always_ff @(posedge i_clk) begin
        if (apply_go) begin
            r_pid  <= n_pid;
            r_time <= n_time;
            r_out  <= rsp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CMP;
            r_cur     <= '0;
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            case (r_state)
                ST_CMP: begin
                    if (cmp_go) begin
                        r_state <= ST_APPLY;
                    end
                end
                ST_APPLY: begin
                    if (apply_go) begin
                        r_state <= ST_CMP;
                    end
                end
                default: begin
                    r_state <= ST_CMP;
                end
            endcase
            if (apply_go) begin
                r_cur     <= n_cur;
                r_count   <= n_count;
                r_out_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_rsp.valid = r_out_vld;
    assign o_rsp.data  = r_out;

endmodule

`default_nettype wire

// ===== src/sorted_timeout_queue_core.sv =====
`default_nettype none

// Channel   Dir  Payload   Handshake
// i_req     in   t_req     valid/ready, beat on valid && ready
// o_rsp     out  t_rsp     valid/ready, beat on valid && ready, one per request beat
// i_cfg_*   in   nudge     write on i_cfg_we, no wait
//
// In the back end each request passes a compare state, which compares the key against
// every queue entry and reads the pid's timeout state, then an apply state, which
// shifts the queue and registers the response. The back end takes no new request
// until the apply state has completed; the front queue registers each request beat.
// Synchronous active-low reset empties the queue and clears all timeout states
// at once through per-pid valid bits; no clearing pass is needed.
// A stalled response holds in its output register; the compare stage still takes
// one more request and the front queue up to two more request beats.

module sorted_timeout_queue_core
    import stq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_we,
    input  wire [NUDGE_W-1:0]   i_cfg_wdata,
    stq_if.sink                 i_req,
    stq_if.source               o_rsp
);

    // classified requests, front side and back side of the decoupling queue
    stq_if #(.t_data(t_cmd)) cmd_in ();
    stq_if #(.t_data(t_cmd)) cmd_out ();

    t_back_stat back_stat;

    // front: nudge register, request decode, nudged wake time
    stq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (i_req),
        .o_cmd       (cmd_in)
    );

    // two-beat queue so front and back stall independently
    stq_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_in),
        .o_cmd   (cmd_out)
    );

    // back: sorted entry array, timeout state memory, response register
    stq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_out),
        .o_rsp   (o_rsp),
        .o_stat  (back_stat)
    );

    // an empty-pop error only ever reports an empty queue
    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.data.error == ERR_EMPTY) |-> o_rsp.data.queue_empty)
        else $error("empty-pop error with non-empty queue");

    // a dropped insert leaves a full, hence non-empty, queue
    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.data.error == ERR_FULL) |-> !o_rsp.data.queue_empty)
        else $error("full error with empty queue");

    // a successful remove clears the pid state and never errors
    a_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.data.found) |->
        (o_rsp.data.error == ERR_OK && o_rsp.data.pid_state == PST_NONE))
        else $error("remove hit with bad status");

    // the entry array cannot be full and empty at once
    a_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_stat.full |-> !back_stat.empty)
        else $error("queue count inconsistent");

endmodule

`default_nettype wire
